### rtl/gfcr_pkg.sv
// Shared types and constants of the gap framed capture ring.
package gfcr_pkg;

	localparam logic KIND_CAPTURE = 1'b0;
	localparam logic KIND_READ    = 1'b1;

	localparam logic REG_GAP_LIMIT = 1'b0;
	localparam logic [15:0] GAP_LIMIT_RESET = 16'd20;

	typedef struct packed {
		logic        kind;
		logic        byte_dir;
		logic [31:0] timestamp;
		logic [7:0]  data_byte;
		logic        burst_last;
		logic [4:0]  read_order;
		logic [7:0]  read_offset;
	} cmd_t;

	typedef struct packed {
		logic        frame_present;
		logic        frame_dir;
		logic [31:0] frame_time;
		logic [8:0]  frame_length;
		logic        byte_valid;
		logic [7:0]  byte_value;
		logic [5:0]  frames_held;
	} rsp_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctl_t;

endpackage

### rtl/gfcr_frame_store.sv
// Frame store: header memory and byte memory, each with a registered read port.
module gfcr_frame_store #(
	parameter int FRAME_SLOTS = 32,
	parameter int FRAME_BYTES = 256
) (
	input  logic                                      clk,
	input  gfcr_pkg::mem_ctl_t                        hdr_ctl,
	input  logic [$clog2(FRAME_SLOTS)-1:0]            hdr_rd_addr,
	input  logic [$clog2(FRAME_SLOTS)-1:0]            hdr_wr_addr,
	input  logic [32+$clog2(FRAME_BYTES+1):0]         hdr_wr_data,
	output logic [32+$clog2(FRAME_BYTES+1):0]         hdr_rd_data,
	input  gfcr_pkg::mem_ctl_t                        byte_ctl,
	input  logic [$clog2(FRAME_SLOTS*FRAME_BYTES)-1:0] byte_rd_addr,
	input  logic [$clog2(FRAME_SLOTS*FRAME_BYTES)-1:0] byte_wr_addr,
	input  logic [7:0]                                byte_wr_data,
	output logic [7:0]                                byte_rd_data
);
	import gfcr_pkg::*;

	localparam int LW = $clog2(FRAME_BYTES + 1);
	localparam int HW = 33 + LW;
	localparam int DEPTH = FRAME_SLOTS * FRAME_BYTES;

	logic [HW-1:0] hdr_mem [FRAME_SLOTS];
	logic [7:0]    byte_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (hdr_ctl.wr_en) begin
			hdr_mem[hdr_wr_addr] <= hdr_wr_data;
		end
		if (hdr_ctl.rd_en) begin
			hdr_rd_data <= hdr_mem[hdr_rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ctl.wr_en) begin
			byte_mem[byte_wr_addr] <= byte_wr_data;
		end
		if (byte_ctl.rd_en) begin
			byte_rd_data <= byte_mem[byte_rd_addr];
		end
	end

endmodule

### rtl/gap_framed_capture_ring.sv
// Bus capture ring: groups captured bytes into frames and serves frame reads.
// Usage:
//   A request is taken at a rising edge with start high and busy low. A capture
//   request (kind 0) stores one byte; it opens a new frame slot, overwriting the
//   oldest, when no frame is open, the direction changes, the time since the
//   last byte exceeds gap_limit_ms, or the open frame is full. It gives no result.
//   A read request (kind 1) addresses a held frame oldest-first by read_order and
//   read_offset; its result is registered from the memories read when the request
//   is taken, and appears on result with done high for one cycle.
//   Each request keeps busy high for one cycle after it is taken, so a new
//   request is taken only once the last is through: the taking edge reads the
//   frame header memory (and, for a read, the byte memory); after it the
//   updated header and byte are written back or the result is registered.
//   The receiver cannot stall; done is a strobe; result holds until the next read.
//   gap_limit_ms sits at APB address 0; write it only while no request is in
//   flight. pready is tied high.
//   Reset empties the ring and sets gap_limit_ms to 20. The memories need no
//   clearing: only headers of opened frames and bytes below a frame length are
//   ever used.
module gap_framed_capture_ring #(
	parameter int FRAME_SLOTS = 32,
	parameter int FRAME_BYTES = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  gfcr_pkg::cmd_t cmd,
	output logic           done,
	output gfcr_pkg::rsp_t result,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);
	import gfcr_pkg::*;

	localparam int SW = $clog2(FRAME_SLOTS);
	localparam int CW = $clog2(FRAME_SLOTS + 1);
	localparam int LW = $clog2(FRAME_BYTES + 1);
	localparam int AW = $clog2(FRAME_SLOTS * FRAME_BYTES);
	localparam int HW = 33 + LW;
	localparam int EW = $clog2(2 * FRAME_SLOTS + 32) + 1;
	localparam int OW = (CW > 5) ? CW : 5;
	localparam int LCW = (LW > 8) ? LW : 8;

	localparam logic [SW-1:0] LAST_SLOT  = SW'(FRAME_SLOTS - 1);
	localparam logic [CW-1:0] SLOTS_C    = CW'(FRAME_SLOTS);
	localparam logic [LW-1:0] BYTES_L    = LW'(FRAME_BYTES);
	localparam logic [AW-1:0] BYTES_A    = AW'(FRAME_BYTES);
	localparam logic [EW-1:0] SLOTS_E    = EW'(FRAME_SLOTS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CAP  = 2'd1;
	localparam logic [1:0] ST_RD   = 2'd2;

	typedef struct packed {
		logic          dir;
		logic [31:0]   start_time;
		logic [LW-1:0] len;
	} hdr_t;

	logic [1:0]    state_q;
	logic [15:0]   gap_q;
	logic [SW-1:0] write_slot_q;
	logic [CW-1:0] held_q;
	logic [SW-1:0] cur_slot_q;
	logic          cur_open_q;
	logic [31:0]   last_time_q;
	cmd_t          cmd_s1;
	logic          done_q;
	rsp_t          result_q;

	logic          accept;
	logic [EW-1:0] rd_sum;
	logic [SW-1:0] rd_slot;
	hdr_t          hdr_rd;
	hdr_t          hdr_wr;
	logic [HW-1:0] hdr_rd_data;
	logic [7:0]    byte_rd_data;
	mem_ctl_t      hdr_ctl;
	mem_ctl_t      byte_ctl;
	logic [SW-1:0] hdr_rd_addr;
	logic [AW-1:0] byte_rd_addr;
	logic [AW-1:0] byte_wr_addr;

	logic          need_new;
	logic [31:0]   gap_delta;
	logic [SW-1:0] cap_slot;
	logic [LW-1:0] cap_len;
	logic [31:0]   cap_time;

	logic          rd_present;
	logic          rd_byte_ok;
	logic          cfg_write;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign result = result_q;
	assign pready = 1'b1;

	// Configuration port
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == REG_GAP_LIMIT) begin
			prdata = {16'd0, gap_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= GAP_LIMIT_RESET;
		end else if (cfg_write && paddr[2] == REG_GAP_LIMIT) begin
			gap_q <= pwdata[15:0];
		end
	end

	// Read slot: oldest frame plus order, wrapped once
	always_comb begin
		rd_sum = EW'(write_slot_q) + SLOTS_E - EW'(held_q) + EW'(cmd.read_order);
		if (rd_sum >= SLOTS_E) begin
			rd_sum = rd_sum - SLOTS_E;
		end
		rd_slot = rd_sum[SW-1:0];
	end

	assign hdr_rd_addr  = (cmd.kind == KIND_CAPTURE) ? cur_slot_q : rd_slot;
	assign byte_rd_addr = AW'(AW'(rd_slot) * BYTES_A) + AW'(cmd.read_offset);

	// Capture decision on the header read back
	assign hdr_rd    = hdr_t'(hdr_rd_data);
	assign gap_delta = cmd_s1.timestamp - last_time_q;
	assign need_new  = !cur_open_q || (hdr_rd.dir != cmd_s1.byte_dir) ||
		(gap_delta > {16'd0, gap_q}) || (hdr_rd.len >= BYTES_L);
	assign cap_slot  = need_new ? write_slot_q : cur_slot_q;
	assign cap_len   = need_new ? '0 : hdr_rd.len;
	assign cap_time  = need_new ? cmd_s1.timestamp : hdr_rd.start_time;

	assign hdr_wr.dir        = cmd_s1.byte_dir;
	assign hdr_wr.start_time = cap_time;
	assign hdr_wr.len        = cap_len + LW'(1);
	assign byte_wr_addr      = AW'(AW'(cap_slot) * BYTES_A) + AW'(cap_len);

	assign hdr_ctl.rd_en  = accept;
	assign hdr_ctl.wr_en  = (state_q == ST_CAP);
	assign byte_ctl.rd_en = accept && (cmd.kind == KIND_READ);
	assign byte_ctl.wr_en = (state_q == ST_CAP);

	gfcr_frame_store #(
		.FRAME_SLOTS(FRAME_SLOTS),
		.FRAME_BYTES(FRAME_BYTES)
	) u_store (
		.clk          (clk),
		.hdr_ctl      (hdr_ctl),
		.hdr_rd_addr  (hdr_rd_addr),
		.hdr_wr_addr  (cap_slot),
		.hdr_wr_data  (HW'(hdr_wr)),
		.hdr_rd_data  (hdr_rd_data),
		.byte_ctl     (byte_ctl),
		.byte_rd_addr (byte_rd_addr),
		.byte_wr_addr (byte_wr_addr),
		.byte_wr_data (cmd_s1.data_byte),
		.byte_rd_data (byte_rd_data)
	);

	// Read result
	assign rd_present = OW'(cmd_s1.read_order) < OW'(held_q);
	assign rd_byte_ok = rd_present && (LCW'(cmd_s1.read_offset) < LCW'(hdr_rd.len));

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
		end
		if (state_q == ST_RD) begin
			result_q.frame_present <= rd_present;
			result_q.frame_dir     <= rd_present ? hdr_rd.dir : 1'b0;
			result_q.frame_time    <= rd_present ? hdr_rd.start_time : 32'd0;
			result_q.frame_length  <= rd_present ? 9'(hdr_rd.len) : 9'd0;
			result_q.byte_valid    <= rd_byte_ok;
			result_q.byte_value    <= rd_byte_ok ? byte_rd_data : 8'd0;
			result_q.frames_held   <= 6'(held_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			done_q       <= 1'b0;
			write_slot_q <= '0;
			held_q       <= '0;
			cur_slot_q   <= '0;
			cur_open_q   <= 1'b0;
			last_time_q  <= 32'd0;
		end else begin
			done_q <= (state_q == ST_RD);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (cmd.kind == KIND_CAPTURE) ? ST_CAP : ST_RD;
					end
				end
				ST_CAP: begin
					if (need_new) begin
						cur_slot_q   <= write_slot_q;
						write_slot_q <= (write_slot_q == LAST_SLOT) ? '0 :
							write_slot_q + SW'(1);
						if (held_q < SLOTS_C) begin
							held_q <= held_q + CW'(1);
						end
						cur_open_q <= 1'b1;
					end
					last_time_q <= cmd_s1.timestamp;
					state_q     <= ST_IDLE;
				end
				ST_RD: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### tb/tb_gap_framed_capture_ring.sv
`timescale 1ns / 1ps
// Self-checking testbench: captures and frame reads against a ring predictor.
module tb_gap_framed_capture_ring;
	import gfcr_pkg::*;

	localparam int SLOTS = 32;
	localparam int BYTES = 256;
	localparam int QUIET_LIMIT = 1000;
	localparam int PHASE_ITEMS = 340;
	localparam int PHASES = 6;

	typedef struct packed {
		cmd_t c;
		logic typed;
		rsp_t r;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	cmd_t        cmd;
	logic        done;
	rsp_t        result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	gap_framed_capture_ring uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predicted ring contents
	logic [7:0]  ring_bytes [SLOTS*BYTES];
	logic [8:0]  ring_len [SLOTS];
	logic        ring_dir [SLOTS];
	logic [31:0] ring_time [SLOTS];
	logic [4:0]  wr_slot;
	logic [4:0]  cur_slot;
	logic [5:0]  held;
	bit          cur_open;
	logic [31:0] last_time;
	logic [15:0] gap_ms;

	rsp_t        pending_reads [$];
	stim_row_t   directed [$];
	rsp_t        want;
	int          mismatches = 0;
	int          quiet_cycles = 0;
	int          idle_pct = 0;

	// burst generator state
	int          gen_left = 0;
	logic        gen_dir = 1'b0;
	logic [31:0] gen_time = 32'd0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task ring_reset();
		for (int i = 0; i < SLOTS*BYTES; i++) ring_bytes[i] = 8'd0;
		for (int i = 0; i < SLOTS; i++) begin
			ring_len[i] = 9'd0;
			ring_dir[i] = 1'b0;
			ring_time[i] = 32'd0;
		end
		wr_slot = 5'd0;
		cur_slot = 5'd0;
		held = 6'd0;
		cur_open = 1'b0;
		last_time = 32'd0;
		gap_ms = GAP_LIMIT_RESET;
	endtask

	task ring_predict(input cmd_t c, output bit produced, output rsp_t r);
		int slot;
		bit open_new;
		r = '0;
		produced = 1'b0;
		if (c.kind == KIND_CAPTURE) begin
			open_new = !cur_open || ring_dir[cur_slot] != c.byte_dir ||
				(c.timestamp - last_time) > {16'd0, gap_ms} || ring_len[cur_slot] >= BYTES;
			if (open_new) begin
				cur_slot = wr_slot;
				wr_slot = wr_slot + 5'd1;
				if (held < SLOTS) held = held + 6'd1;
				cur_open = 1'b1;
				ring_dir[cur_slot] = c.byte_dir;
				ring_time[cur_slot] = c.timestamp;
				ring_len[cur_slot] = 9'd0;
			end
			if (ring_len[cur_slot] < BYTES) begin
				ring_bytes[cur_slot*BYTES + ring_len[cur_slot]] = c.data_byte;
				ring_len[cur_slot] = ring_len[cur_slot] + 9'd1;
			end
			last_time = c.timestamp;
		end else begin
			produced = 1'b1;
			r.frames_held = held;
			if (c.read_order < held) begin
				slot = (wr_slot + SLOTS - held + c.read_order) % SLOTS;
				r.frame_present = 1'b1;
				r.frame_dir = ring_dir[slot];
				r.frame_time = ring_time[slot];
				r.frame_length = ring_len[slot];
				if (c.read_offset < ring_len[slot]) begin
					r.byte_valid = 1'b1;
					r.byte_value = ring_bytes[slot*BYTES + c.read_offset];
				end
			end
		end
	endtask

	function automatic cmd_t cap(logic d, logic [31:0] t, logic [7:0] b, logic last);
		cmd_t c;
		c = '0;
		c.kind = KIND_CAPTURE;
		c.byte_dir = d;
		c.timestamp = t;
		c.data_byte = b;
		c.burst_last = last;
		return c;
	endfunction

	function automatic cmd_t rd(logic [4:0] o, logic [7:0] off);
		cmd_t c;
		c = '0;
		c.kind = KIND_READ;
		c.read_order = o;
		c.read_offset = off;
		return c;
	endfunction

	function automatic rsp_t frame_rsp(logic p, logic d, logic [31:0] t, logic [8:0] len,
			logic v, logic [7:0] b, logic [5:0] h);
		rsp_t r;
		r.frame_present = p;
		r.frame_dir = d;
		r.frame_time = t;
		r.frame_length = len;
		r.byte_valid = v;
		r.byte_value = b;
		r.frames_held = h;
		return r;
	endfunction

	task add_row(input cmd_t c, input logic typed, input rsp_t r);
		stim_row_t row;
		row.c = c;
		row.typed = typed;
		row.r = r;
		directed.push_back(row);
	endtask

	task make_random_cmd(output cmd_t c);
		int slot;
		int len;
		int step;
		int pick;
		c.byte_dir = 1'($urandom_range(1));
		c.timestamp = $urandom();
		c.data_byte = 8'($urandom());
		c.burst_last = 1'($urandom_range(1));
		c.read_order = 5'($urandom());
		c.read_offset = 8'($urandom());
		pick = $urandom_range(99);
		if (pick < 25) begin
			c.kind = KIND_READ;
			pick = $urandom_range(99);
			if (held != 0 && pick < 70) c.read_order = 5'($urandom_range(held - 1));
			else if (pick < 85) c.read_order = 5'(held);
			if (c.read_order < held) begin
				slot = (wr_slot + SLOTS - held + c.read_order) % SLOTS;
				len = ring_len[slot];
				if (len != 0 && $urandom_range(99) < 65)
					c.read_offset = 8'($urandom_range(len - 1));
			end
		end else if (pick < 32) begin
			// noise: a capture with random content
			c.kind = KIND_CAPTURE;
		end else begin
			c.kind = KIND_CAPTURE;
			if (gen_left == 0) begin
				gen_left = ($urandom_range(59) == 0) ? $urandom_range(300, 250)
					: $urandom_range(16, 1);
				if ($urandom_range(3) == 0) gen_dir = ~gen_dir;
				case ($urandom_range(9))
					0: step = 0;
					1, 2, 3: step = $urandom_range(gap_ms);
					4: step = gap_ms;
					5: step = gap_ms + 1;
					6: step = gap_ms + 1 + $urandom_range(1000);
					7: step = $urandom();
					8: step = -int'($urandom_range(100, 1));
					default: step = $urandom_range(5);
				endcase
				gen_time = gen_time + 32'(step);
			end else if ($urandom_range(7) == 0) begin
				// advance the burst time by at most the gap limit
				gen_time = gen_time + 32'($urandom_range(gap_ms));
			end
			gen_left--;
			c.byte_dir = gen_dir;
			c.timestamp = gen_time;
			c.burst_last = (gen_left == 0) ^ ($urandom_range(19) == 0);
		end
	endtask

	task send_request(input cmd_t c, input bit drain, input logic typed, input rsp_t typed_rsp);
		int gaps;
		bit produced;
		rsp_t predicted;
		gaps = 0;
		while ($urandom_range(99) < idle_pct) gaps++;
		if (drain || gaps > 0) begin
			start <= 1'b0;
			@(posedge clk);
			// hold off until every outstanding read has answered
			while (drain && pending_reads.size() != 0) @(posedge clk);
			repeat (gaps) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		ring_predict(c, produced, predicted);
		if (produced) pending_reads.push_back(typed ? typed_rsp : predicted);
	endtask

	task write_gap(input logic [15:0] v);
		start <= 1'b0;
		@(posedge clk);
		while (pending_reads.size() != 0) @(posedge clk);
		// let a trailing capture finish its write-back
		repeat (4) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_GAP_LIMIT, 2'b00};
		pwdata <= {16'($urandom()), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		gap_ms = v;
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_reads.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected read response %h", result);
			end else begin
				want = pending_reads.pop_front();
				if (result.frame_present !== want.frame_present ||
						result.frame_dir !== want.frame_dir ||
						result.frame_time !== want.frame_time ||
						result.frame_length !== want.frame_length ||
						result.byte_valid !== want.byte_valid ||
						result.byte_value !== want.byte_value ||
						result.frames_held !== want.frames_held) begin
					mismatches++;
					if (mismatches <= 10)
						$display("read mismatch: exp p%0d d%0d t%h l%0d v%0d b%h h%0d",
							want.frame_present, want.frame_dir, want.frame_time,
							want.frame_length, want.byte_valid, want.byte_value,
							want.frames_held,
							" got p%0d d%0d t%h l%0d v%0d b%h h%0d",
							result.frame_present, result.frame_dir, result.frame_time,
							result.frame_length, result.byte_valid, result.byte_value,
							result.frames_held);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("tb: failure");
		$finish;
	end

	initial begin : stimulus
		cmd_t c;
		logic [15:0] gap_val;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 3'd0;
		pwdata = 32'd0;
		ring_reset();

		// empty ring
		add_row(rd(5'd0, 8'd0), 1'b1, '0);
		add_row(rd(5'd31, 8'd255), 1'b1, '0);
		add_row(cap(1'b0, 32'd100, 8'h00, 1'b0), 1'b0, '0);
		add_row(cap(1'b0, 32'd110, 8'hFF, 1'b1), 1'b0, '0);
		add_row(rd(5'd0, 8'd1), 1'b1,
			frame_rsp(1'b1, 1'b0, 32'd100, 9'd2, 1'b1, 8'hFF, 6'd1));
		// offset beyond length
		add_row(rd(5'd0, 8'd2), 1'b1,
			frame_rsp(1'b1, 1'b0, 32'd100, 9'd2, 1'b0, 8'h00, 6'd1));
		// absent frame
		add_row(rd(5'd1, 8'd0), 1'b1,
			frame_rsp(1'b0, 1'b0, 32'd0, 9'd0, 1'b0, 8'h00, 6'd1));
		// direction change, gap one above the limit, gap at the limit
		add_row(cap(1'b1, 32'd115, 8'hA5, 1'b0), 1'b0, '0);
		add_row(cap(1'b1, 32'd136, 8'h5A, 1'b0), 1'b0, '0);
		add_row(cap(1'b1, 32'd156, 8'h0F, 1'b1), 1'b0, '0);
		// timestamp going back, then a wrap across zero inside one frame
		add_row(cap(1'b1, 32'd100, 8'h3C, 1'b0), 1'b0, '0);
		add_row(cap(1'b1, 32'hFFFF_FFFE, 8'h80, 1'b0), 1'b0, '0);
		add_row(cap(1'b1, 32'h0000_0003, 8'h7F, 1'b1), 1'b0, '0);
		add_row(rd(5'd1, 8'd0), 1'b1,
			frame_rsp(1'b1, 1'b1, 32'd115, 9'd1, 1'b1, 8'hA5, 6'd5));
		add_row(rd(5'd2, 8'd1), 1'b1,
			frame_rsp(1'b1, 1'b1, 32'd136, 9'd2, 1'b1, 8'h0F, 6'd5));
		add_row(rd(5'd3, 8'd0), 1'b0, '0);
		add_row(rd(5'd4, 8'd1), 1'b1,
			frame_rsp(1'b1, 1'b1, 32'hFFFF_FFFE, 9'd2, 1'b1, 8'h7F, 6'd5));
		add_row(rd(5'd4, 8'd255), 1'b1,
			frame_rsp(1'b1, 1'b1, 32'hFFFF_FFFE, 9'd2, 1'b0, 8'h00, 6'd5));
		add_row(rd(5'd5, 8'd0), 1'b1,
			frame_rsp(1'b0, 1'b0, 32'd0, 9'd0, 1'b0, 8'h00, 6'd5));
		add_row(cap(1'b1, 32'h0000_0003, 8'hC3, 1'b0), 1'b0, '0);
		add_row(cap(1'b0, 32'h0000_0003, 8'h11, 1'b1), 1'b0, '0);
		add_row(rd(5'd5, 8'd0), 1'b0, '0);
		add_row(rd(5'd4, 8'd2), 1'b0, '0);
		add_row(rd(5'd31, 8'd0), 1'b1,
			frame_rsp(1'b0, 1'b0, 32'd0, 9'd0, 1'b0, 8'h00, 6'd6));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		idle_pct = 14;
		foreach (directed[i])
			send_request(directed[i].c, 1'b0, directed[i].typed, directed[i].r);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: gap_val = 16'd0;
				1: gap_val = 16'hFFFF;
				2: gap_val = GAP_LIMIT_RESET;
				3: gap_val = 16'($urandom());
				4: gap_val = 16'd1;
				default: gap_val = 16'($urandom_range(200));
			endcase
			write_gap(gap_val);
			idle_pct = (p < 2) ? 14 : (p < 4) ? 67 : 0;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				make_random_cmd(c);
				send_request(c, (i == PHASE_ITEMS / 2) || ($urandom_range(199) == 0),
					1'b0, '0);
			end
		end

		start <= 1'b0;
		@(posedge clk);
		while (pending_reads.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule

### sim.f
rtl/gfcr_pkg.sv
rtl/gfcr_frame_store.sv
rtl/gap_framed_capture_ring.sv
tb/tb_gap_framed_capture_ring.sv
